>>> sv/tbp_pkg.sv
`default_nettype none
package tbp_pkg;

	localparam int PULSE_W     = 12;
	localparam int BYTE_W      = 8;
	localparam int MODE_W      = 3;
	localparam int CFG_INDEX_W = 2;
	localparam int STEP_W      = 5;

	localparam int DEFAULT_QUEUE_DEPTH = 4;

	localparam logic [PULSE_W-1:0] SHORT_RESET  = 12'd176;
	localparam logic [PULSE_W-1:0] MEDIUM_RESET = 12'd256;
	localparam logic [PULSE_W-1:0] LONG_RESET   = 12'd336;

	// byte symbols: marker (2) + 8 bits (16) + parity (2) pulses
	localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 5'd19;
	localparam logic [STEP_W-1:0] END_LAST_STEP  = 5'd1;
	localparam logic [STEP_W-1:0] ONE_LAST_STEP  = 5'd0;
	localparam logic [STEP_W-1:0] PARITY_STEP    = 5'd18;

	typedef enum logic [MODE_W-1:0] {
		MODE_DATA = 3'd0,
		MODE_RAW  = 3'd1,
		MODE_CSUM = 3'd2,
		MODE_SYNC = 3'd3,
		MODE_LONG = 3'd4,
		MODE_END  = 3'd5
	} mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SHORT  = 2'd0,
		CFG_MEDIUM = 2'd1,
		CFG_LONG   = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		CMD_BYTE = 2'd0,
		CMD_SYNC = 2'd1,
		CMD_LONG = 2'd2,
		CMD_END  = 2'd3
	} cmd_kind_t;

	typedef enum logic [1:0] {
		PULSE_SHORT  = 2'd0,
		PULSE_MEDIUM = 2'd1,
		PULSE_LONG   = 2'd2
	} pulse_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [BYTE_W-1:0]  data;
	} cmd_t;

	typedef struct packed {
		logic [PULSE_W-1:0] short_us;
		logic [PULSE_W-1:0] medium_us;
		logic [PULSE_W-1:0] long_us;
	} pulse_cfg_t;

	// queue handshake toward the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

endpackage
`default_nettype wire

>>> sv/tape_byte_pulse_encoder_unit.sv
// Tape pulse encoder. Each symbol request on the slave side becomes pulse
// lengths on the master side, one pulse per cycle unless m_tready stalls the
// output: a byte (data, raw or checksum) gives 20 pulses, an end marker 2,
// sync and long 1 each; modes 6 and 7 are dropped. The output sequencer sets
// the pace, and the input side keeps accepting while a queue of QUEUE_DEPTH
// symbols has room. tlast marks the final pulse of each symbol. Pulse lengths
// come from three 12-bit registers (short, medium, long); write them only
// while the block is idle.
`default_nettype none
module tape_byte_pulse_encoder_unit #(
	parameter int QUEUE_DEPTH = tbp_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [15:0]                       s_tdata,   // mode[2:0], data_byte[10:3]
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [15:0]                            m_tdata,   // pulse_us[11:0]
	output logic                                   m_tlast,
	input  wire logic                              cfg_we,
	input  wire logic [tbp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [tbp_pkg::PULSE_W-1:0]       cfg_data
);

	tbp_pkg::pulse_cfg_t           cfg_q;
	logic                          accept;
	logic                          push;
	tbp_pkg::cmd_t                 push_cmd;
	logic                          full;
	logic                          pop;
	tbp_pkg::queue_head_t          head;
	logic [tbp_pkg::PULSE_W-1:0]   pulse;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_us  <= tbp_pkg::SHORT_RESET;
			cfg_q.medium_us <= tbp_pkg::MEDIUM_RESET;
			cfg_q.long_us   <= tbp_pkg::LONG_RESET;
		end else if (cfg_we) begin
			case (tbp_pkg::cfg_index_t'(cfg_index))
				tbp_pkg::CFG_SHORT:  cfg_q.short_us  <= cfg_data;
				tbp_pkg::CFG_MEDIUM: cfg_q.medium_us <= cfg_data;
				tbp_pkg::CFG_LONG:   cfg_q.long_us   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = !full;
	assign accept   = s_tvalid && !full;

	tbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.mode      (s_tdata[2:0]),
		.data_byte (s_tdata[10:3]),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	tbp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head)
	);

	tbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pulse (pulse),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'd0, pulse};

endmodule
`default_nettype wire

>>> sv/tbp_front.sv
`default_nettype none
module tbp_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic [tbp_pkg::MODE_W-1:0]   mode,
	input  wire logic [tbp_pkg::BYTE_W-1:0]   data_byte,
	output logic                              push,
	output tbp_pkg::cmd_t                     push_cmd
);

	logic [tbp_pkg::BYTE_W-1:0] checksum_q;
	logic                       csum_xor;
	logic                       csum_clear;

	always_comb begin
		push            = 1'b0;
		push_cmd.kind   = tbp_pkg::CMD_BYTE;
		push_cmd.data   = data_byte;
		csum_xor        = 1'b0;
		csum_clear      = 1'b0;
		case (tbp_pkg::mode_t'(mode))
			tbp_pkg::MODE_DATA: begin
				push     = accept;
				csum_xor = accept;
			end
			tbp_pkg::MODE_RAW: begin
				push = accept;
			end
			tbp_pkg::MODE_CSUM: begin
				push          = accept;
				push_cmd.data = checksum_q;
				csum_clear    = accept;
			end
			tbp_pkg::MODE_SYNC: begin
				push          = accept;
				push_cmd.kind = tbp_pkg::CMD_SYNC;
			end
			tbp_pkg::MODE_LONG: begin
				push          = accept;
				push_cmd.kind = tbp_pkg::CMD_LONG;
			end
			tbp_pkg::MODE_END: begin
				push          = accept;
				push_cmd.kind = tbp_pkg::CMD_END;
			end
			default: begin
				push = 1'b0;  // unused modes are dropped
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checksum_q <= '0;
		end else if (csum_clear) begin
			checksum_q <= '0;
		end else if (csum_xor) begin
			checksum_q <= checksum_q ^ data_byte;
		end
	end

endmodule
`default_nettype wire

>>> sv/tbp_queue.sv
`default_nettype none
module tbp_queue #(
	parameter int DEPTH = tbp_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire tbp_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output tbp_pkg::queue_head_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tbp_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/tbp_back.sv
`default_nettype none
module tbp_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tbp_pkg::pulse_cfg_t           cfg,
	input  wire tbp_pkg::queue_head_t          head,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [tbp_pkg::PULSE_W-1:0]        out_pulse,
	output logic                               out_last
);

	logic                          cur_valid_q;
	tbp_pkg::cmd_kind_t            cur_kind_q;
	logic [tbp_pkg::BYTE_W-1:0]    cur_byte_q;
	logic [tbp_pkg::STEP_W-1:0]    step_q;

	logic                          out_valid_q;
	logic [tbp_pkg::PULSE_W-1:0]   out_pulse_q;
	logic                          out_last_q;

	logic                          load_out;
	logic                          cur_done;
	logic [tbp_pkg::STEP_W-1:0]    last_step;
	logic [tbp_pkg::STEP_W-1:0]    step_m2;
	logic                          cur_bit;
	tbp_pkg::pulse_kind_t          pk;
	logic [tbp_pkg::PULSE_W-1:0]   pulse_len;

	assign step_m2 = step_q - tbp_pkg::STEP_W'(2);

	always_comb begin
		last_step = tbp_pkg::ONE_LAST_STEP;
		pk        = tbp_pkg::PULSE_SHORT;
		cur_bit   = 1'b0;
		case (cur_kind_q)
			tbp_pkg::CMD_BYTE: begin
				last_step = tbp_pkg::BYTE_LAST_STEP;
				if (step_q >= tbp_pkg::PARITY_STEP) begin
					cur_bit = ~(^cur_byte_q);  // set when the count of ones is even
				end else begin
					cur_bit = cur_byte_q[step_m2[3:1]];
				end
				if (step_q == '0) begin
					pk = tbp_pkg::PULSE_LONG;
				end else if (step_q == tbp_pkg::STEP_W'(1)) begin
					pk = tbp_pkg::PULSE_MEDIUM;
				end else if (cur_bit ^ step_q[0]) begin
					// one: medium then short; zero: short then medium
					pk = tbp_pkg::PULSE_MEDIUM;
				end else begin
					pk = tbp_pkg::PULSE_SHORT;
				end
			end
			tbp_pkg::CMD_SYNC: begin
				pk = tbp_pkg::PULSE_SHORT;
			end
			tbp_pkg::CMD_LONG: begin
				pk = tbp_pkg::PULSE_LONG;
			end
			tbp_pkg::CMD_END: begin
				last_step = tbp_pkg::END_LAST_STEP;
				pk = (step_q == '0) ? tbp_pkg::PULSE_LONG : tbp_pkg::PULSE_SHORT;
			end
			default: begin
				pk = tbp_pkg::PULSE_SHORT;
			end
		endcase
	end

	always_comb begin
		case (pk)
			tbp_pkg::PULSE_SHORT:  pulse_len = cfg.short_us;
			tbp_pkg::PULSE_MEDIUM: pulse_len = cfg.medium_us;
			tbp_pkg::PULSE_LONG:   pulse_len = cfg.long_us;
			default:               pulse_len = cfg.short_us;
		endcase
	end

	assign load_out = cur_valid_q && (!out_valid_q || out_ready);
	assign cur_done = load_out && (step_q == last_step);
	assign pop      = head.valid && (!cur_valid_q || cur_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			step_q      <= '0;
		end else if (cur_done) begin
			cur_valid_q <= 1'b0;
		end else if (load_out) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_kind_q <= head.cmd.kind;
			cur_byte_q <= head.cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pulse_q <= pulse_len;
			out_last_q  <= (step_q == last_step);
		end
	end

	assign out_valid = out_valid_q;
	assign out_pulse = out_pulse_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire
